/* sv/keyword_lexer_stream_top_macros.svh */
// Assertion macros for the keyword lexer stream block.
`ifndef KEYWORD_LEXER_STREAM_TOP_MACROS_SVH
`define KEYWORD_LEXER_STREAM_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define KLS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kls assertion failed");
// next-cycle implication, checked outside reset
`define KLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kls assertion failed");
`else
`define KLS_ASSERT_IMPLIES(lbl, ante, cons)
`define KLS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/kls_pkg.sv */
// Shared types, token codes and helpers for the keyword lexer stream block.
`timescale 1ns / 1ps
`default_nettype none
package kls_pkg;

  // source offset counter width
  localparam int POS_BITS = 16;

  localparam int KIND_W  = 5;
  localparam int VALUE_W = 31;
  localparam int LEN_W   = 16;

  localparam logic [VALUE_W-1:0] NUM_MAX = {VALUE_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX = {LEN_W{1'b1}};

  // token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_KW_BASE = 5'd2;
  localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd9;
  localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd10;
  localparam logic [KIND_W-1:0] KIND_STAR    = 5'd11;
  localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd12;
  localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd13;
  localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd14;
  localparam logic [KIND_W-1:0] KIND_EOF     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 5'd16;

  // keyword table: first bytes packed little-endian, then length
  localparam int NUM_KW = 7;
  localparam int KW_BYTES = 6;
  localparam logic [8*KW_BYTES-1:0] KW_TEXT [NUM_KW] = '{
    48'h000000726176,  // var
    48'h00746E697270,  // print
    48'h000000006669,  // if
    48'h000065736C65,  // else
    48'h00656C696877,  // while
    48'h0000636E7566,  // func
    48'h6E7275746572   // return
  };
  localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
    16'd3, 16'd5, 16'd2, 16'd4, 16'd5, 16'd4, 16'd6
  };

  // token queue between scanner and output stage
  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] number_value;
    logic               overflowed;
    logic [LEN_W-1:0]   start_pos;
    logic [LEN_W-1:0]   token_len;
    logic               last_of_run;
  } tok_t;

  // up to two tokens written by the scanner in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       a;
    tok_t       b;
  } push_t;

  typedef struct packed {
    logic             nonempty;
    logic             full;
    logic [LVL_W-1:0] level;
  } qstat_t;

  // clamp a source offset to the 16-bit output field
  function automatic logic [LEN_W-1:0] sat_pos(input logic [POS_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    if (w > 32'(LEN_MAX)) begin
      return LEN_MAX;
    end
    return w[LEN_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/kls_front.sv */
// Scanner front end: classifies bytes, tracks the open lexeme, forms tokens.
`timescale 1ns / 1ps
`default_nettype none
module kls_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    ch,
  input  wire logic          eos,
  output kls_pkg::push_t     push
);
  import kls_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_ERROR  = 2'd3;

  logic [1:0]            mode_r,   mode_nxt;
  logic [8*KW_BYTES-1:0] kwbuf_r,  kwbuf_nxt;
  logic                  kwpos_r,  kwpos_nxt;
  logic [LEN_W-1:0]      runlen_r, runlen_nxt;
  logic [VALUE_W-1:0]    acc_r,    acc_nxt;
  logic                  ovf_r,    ovf_nxt;
  logic [POS_BITS-1:0]   pos_r,    pos_nxt;
  logic [POS_BITS-1:0]   tstart_r, tstart_nxt;

  logic              term, is_alpha, is_digit, is_space, is_word, is_op;
  logic [KIND_W-1:0] op_kind, id_kind;
  logic [34:0]       acc_sum;
  logic [POS_BITS-1:0] pos_inc;
  logic [LEN_W-1:0]  runlen_inc;

  // byte classes
  assign term     = eos || (ch == 8'h00);
  assign is_alpha = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  assign is_digit = (ch >= 8'h30 && ch <= 8'h39);
  assign is_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
  assign is_word  = is_alpha || is_digit || (ch == 8'h5F);

  always_comb begin
    is_op   = 1'b1;
    op_kind = KIND_PLUS;
    unique case (ch)
      8'h2B:   op_kind = KIND_PLUS;
      8'h2D:   op_kind = KIND_MINUS;
      8'h2A:   op_kind = KIND_STAR;
      8'h2F:   op_kind = KIND_SLASH;
      8'h3D:   op_kind = KIND_ASSIGN;
      8'h3B:   op_kind = KIND_SEMI;
      default: is_op = 1'b0;
    endcase
  end

  // keyword match on the buffered identifier
  always_comb begin
    id_kind = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kwpos_r && runlen_r == KW_LEN[k] && kwbuf_r == KW_TEXT[k]) begin
        id_kind = KIND_W'(KIND_KW_BASE + KIND_W'(k));
      end
    end
  end

  // decimal accumulate: acc * 10 + digit
  assign acc_sum    = 35'(acc_r) * 35'd10 + 35'(ch[3:0]);
  assign pos_inc    = (pos_r == {POS_BITS{1'b1}}) ? pos_r : pos_r + 1'b1;
  assign runlen_inc = (runlen_r == LEN_MAX) ? runlen_r : runlen_r + 1'b1;

  // next state and token formation
  always_comb begin
    tok_t close_tok, sec_tok;
    logic close_v, sec_v;

    mode_nxt   = mode_r;
    kwbuf_nxt  = kwbuf_r;
    kwpos_nxt  = kwpos_r;
    runlen_nxt = runlen_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    close_tok  = '0;
    sec_tok    = '0;
    close_v    = 1'b0;
    sec_v      = 1'b0;
    push       = '0;

    if (accept) begin
      if (!term && mode_r == MODE_IDENT && is_word) begin
        // extend identifier
        for (int i = 0; i < KW_BYTES; i++) begin
          if (runlen_r == LEN_W'(i)) begin
            kwbuf_nxt[8*i +: 8] = ch;
          end
        end
        if (runlen_r >= LEN_W'(KW_BYTES)) begin
          kwpos_nxt = 1'b0;
        end
        runlen_nxt = runlen_inc;
        pos_nxt    = pos_inc;
      end else if (!term && mode_r == MODE_NUMBER && is_digit) begin
        // extend number
        if (acc_sum > 35'(NUM_MAX)) begin
          acc_nxt = NUM_MAX;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = acc_sum[VALUE_W-1:0];
        end
        runlen_nxt = runlen_inc;
        pos_nxt    = pos_inc;
      end else begin
        // close the open lexeme, if any
        if (mode_r == MODE_IDENT) begin
          close_v             = 1'b1;
          close_tok.kind      = id_kind;
          close_tok.start_pos = sat_pos(tstart_r);
          close_tok.token_len = runlen_r;
          mode_nxt            = MODE_IDLE;
        end else if (mode_r == MODE_NUMBER) begin
          close_v                = 1'b1;
          close_tok.kind         = KIND_NUMBER;
          close_tok.number_value = acc_r;
          close_tok.overflowed   = ovf_r;
          close_tok.start_pos    = sat_pos(tstart_r);
          close_tok.token_len    = runlen_r;
          mode_nxt               = MODE_IDLE;
        end

        if (term) begin
          // eof, then back to the reset state
          sec_v             = 1'b1;
          sec_tok.kind      = KIND_EOF;
          sec_tok.start_pos = sat_pos(pos_r);
          mode_nxt   = MODE_IDLE;
          kwbuf_nxt  = '0;
          kwpos_nxt  = 1'b1;
          runlen_nxt = '0;
          acc_nxt    = '0;
          ovf_nxt    = 1'b0;
          pos_nxt    = '0;
          tstart_nxt = '0;
        end else begin
          if (!(mode_r == MODE_ERROR || is_space)) begin
            kwbuf_nxt  = '0;
            kwpos_nxt  = 1'b1;
            runlen_nxt = '0;
            acc_nxt    = '0;
            ovf_nxt    = 1'b0;
            tstart_nxt = pos_r;
            if (is_alpha || ch == 8'h5F) begin
              mode_nxt   = MODE_IDENT;
              kwbuf_nxt  = {{(8*KW_BYTES-8){1'b0}}, ch};
              runlen_nxt = LEN_W'(1);
            end else if (is_digit) begin
              mode_nxt   = MODE_NUMBER;
              acc_nxt    = VALUE_W'(ch[3:0]);
              runlen_nxt = LEN_W'(1);
            end else if (is_op) begin
              sec_v             = 1'b1;
              sec_tok.kind      = op_kind;
              sec_tok.start_pos = sat_pos(pos_r);
              sec_tok.token_len = LEN_W'(1);
            end else begin
              // unknown byte: report and ignore until end of source
              sec_v             = 1'b1;
              sec_tok.kind      = KIND_ERROR;
              sec_tok.start_pos = sat_pos(pos_r);
              mode_nxt          = MODE_ERROR;
            end
          end
          pos_nxt = pos_inc;
        end
      end

      // pack into queue write slots, mark last of this byte
      if (close_v && sec_v) begin
        sec_tok.last_of_run = 1'b1;
        push.cnt = 2'd2;
        push.a   = close_tok;
        push.b   = sec_tok;
      end else if (close_v) begin
        close_tok.last_of_run = 1'b1;
        push.cnt = 2'd1;
        push.a   = close_tok;
      end else if (sec_v) begin
        sec_tok.last_of_run = 1'b1;
        push.cnt = 2'd1;
        push.a   = sec_tok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      kwbuf_r  <= '0;
      kwpos_r  <= 1'b1;
      runlen_r <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      pos_r    <= '0;
      tstart_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      kwbuf_r  <= kwbuf_nxt;
      kwpos_r  <= kwpos_nxt;
      runlen_r <= runlen_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/kls_queue.sv */
// Token queue: up to two writes and one read per cycle between scanner and output.
`timescale 1ns / 1ps
`default_nettype none
module kls_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire kls_pkg::push_t push,
  input  wire logic           pop,
  output kls_pkg::tok_t       head,
  output kls_pkg::qstat_t     stat
);
  import kls_pkg::*;

  tok_t             ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r,  level_nxt;

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign level_nxt  = level_r + LVL_W'(push.cnt) - LVL_W'(pop);

  assign head          = ent_r[rd_ptr_r];
  assign stat.nonempty = (level_r != '0);
  assign stat.full     = (level_r > LVL_W'(DEPTH - 2));
  assign stat.level    = level_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent_r[wr_ptr_r] <= push.a;
    end
    if (push.cnt == 2'd2) begin
      ent_r[wr_ptr_r + PTR_W'(1)] <= push.b;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/kls_back.sv */
// Output stage: holds the oldest token until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module kls_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kls_pkg::tok_t head,
  input  wire logic          nonempty,
  input  wire logic          out_pop,
  output logic               q_pop,
  output logic               out_empty,
  output kls_pkg::tok_t      out_tok
);
  import kls_pkg::*;

  logic valid_r, valid_nxt;
  tok_t tok_r;

  // refill when the slot is free or its token transfers this cycle
  assign q_pop     = nonempty && (!valid_r || out_pop);
  assign valid_nxt = q_pop || (valid_r && !out_pop);
  assign out_empty = !valid_r;
  assign out_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tok_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/keyword_lexer_stream_top.sv */
// Keyword lexer stream: top level joining scanner, token queue and output stage.
// The first token caused by a byte is written to the token queue, then registered in the
// output stage driving the result ports; a second token from the same byte follows it.
// Throughput: one byte per cycle while the queue is not full and results are taken at one
// per cycle; the four-entry token queue reports full once more than two tokens wait in it.
// Reset: synchronous, active low; clears scanner state, queue pointers and output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "keyword_lexer_stream_top_macros.svh"
module keyword_lexer_stream_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [7:0]                    in_ch,
  input  wire logic                          in_end_of_source,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [kls_pkg::KIND_W-1:0]         out_kind,
  output logic [kls_pkg::VALUE_W-1:0]        out_number_value,
  output logic                               out_overflowed,
  output logic [kls_pkg::LEN_W-1:0]          out_start_pos,
  output logic [kls_pkg::LEN_W-1:0]          out_token_len,
  output logic                               out_last_of_run
);
  import kls_pkg::*;

  logic   in_accept;
  push_t  push;
  tok_t   head;
  qstat_t q_stat;
  logic   q_pop;
  tok_t   out_tok;

  assign in_full   = q_stat.full;
  assign in_accept = in_push && !q_stat.full;

  kls_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .ch     (in_ch),
    .eos    (in_end_of_source),
    .push   (push)
  );

  kls_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .head  (head),
    .stat  (q_stat)
  );

  kls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .nonempty  (q_stat.nonempty),
    .out_pop   (out_pop),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_tok   (out_tok)
  );

  assign out_kind         = out_tok.kind;
  assign out_number_value = out_tok.number_value;
  assign out_overflowed   = out_tok.overflowed;
  assign out_start_pos    = out_tok.start_pos;
  assign out_token_len    = out_tok.token_len;
  assign out_last_of_run  = out_tok.last_of_run;

  // scanner writes the queue only for a transferred byte
  `KLS_ASSERT_IMPLIES(a_push_on_accept, push.cnt != 2'd0, in_accept)
  // a two-token write marks only the second token as last of its byte
  `KLS_ASSERT_IMPLIES(a_pair_last, push.cnt == 2'd2, !push.a.last_of_run && push.b.last_of_run)
  // queue never overfills
  `KLS_ASSERT_IMPLIES(a_level_bound, 1'b1, q_stat.level <= LVL_W'(DEPTH))
  // a token waiting in the queue reaches an empty output slot next cycle
  `KLS_ASSERT_NEXT(a_refill, q_stat.nonempty && out_empty, !out_empty)

endmodule
`default_nettype wire

/* verif/kls_checker.sv */
// Checker for the keyword lexer stream: predicts the token stream and compares results.
`timescale 1ns / 1ps
module kls_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  input  wire logic                        in_full,
  input  wire logic [7:0]                  in_ch,
  input  wire logic                        in_end_of_source,
  input  wire logic                        out_empty,
  input  wire logic                        out_pop,
  input  wire logic [kls_pkg::KIND_W-1:0]  out_kind,
  input  wire logic [kls_pkg::VALUE_W-1:0] out_number_value,
  input  wire logic                        out_overflowed,
  input  wire logic [kls_pkg::LEN_W-1:0]   out_start_pos,
  input  wire logic [kls_pkg::LEN_W-1:0]   out_token_len,
  input  wire logic                        out_last_of_run,
  output int                               fail_count,
  output int                               pending,
  output int                               tokens_checked
);
  import kls_pkg::*;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_ERROR} scan_t;

  // scanner model state
  scan_t               scan_st;
  logic [8*KW_BYTES-1:0] kw_buf;
  bit                  kw_maybe;
  logic [LEN_W-1:0]    run_len;
  logic [VALUE_W-1:0]  accum;
  bit                  accum_ovf;
  logic [POS_BITS-1:0] src_pos;
  logic [POS_BITS-1:0] tok_start;

  // tokens predicted but not yet seen on the result side
  tok_t expected_tokens[$];

  initial begin
    fail_count     = 0;
    tokens_checked = 0;
    pending        = 0;
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_space_char(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return is_letter(c) || is_digit_char(c) || c == "_";
  endfunction

  function automatic logic [LEN_W-1:0] clamp_pos(input logic [POS_BITS-1:0] p);
    logic [31:0] wide;
    wide = 32'(p);
    return (wide > 32'(LEN_MAX)) ? LEN_MAX : wide[LEN_W-1:0];
  endfunction

  function automatic void clear_lexeme();
    kw_buf    = '0;
    kw_maybe  = 1'b1;
    run_len   = '0;
    accum     = '0;
    accum_ovf = 1'b0;
  endfunction

  function automatic void reset_scanner();
    scan_st   = SCAN_IDLE;
    clear_lexeme();
    src_pos   = '0;
    tok_start = '0;
  endfunction

  function automatic void step_pos();
    if (src_pos != {POS_BITS{1'b1}}) src_pos = src_pos + 1'b1;
  endfunction

  function automatic void grow_ident(input logic [7:0] c);
    if (run_len < LEN_W'(KW_BYTES)) kw_buf[8*run_len +: 8] = c;
    else kw_maybe = 1'b0;
    if (run_len != LEN_MAX) run_len = run_len + 1'b1;
  endfunction

  function automatic void grow_number(input logic [7:0] c);
    logic [VALUE_W+3:0] v;
    v = (35'(accum) * 35'd10) + 35'(c - "0");
    if (v > 35'(NUM_MAX)) begin
      v = 35'(NUM_MAX);
      accum_ovf = 1'b1;
    end
    accum = v[VALUE_W-1:0];
    if (run_len != LEN_MAX) run_len = run_len + 1'b1;
  endfunction

  function automatic logic [KIND_W-1:0] ident_kind();
    if (!kw_maybe) return KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (run_len == KW_LEN[k] && kw_buf == KW_TEXT[k]) return KIND_KW_BASE + KIND_W'(k);
    end
    return KIND_IDENT;
  endfunction

  function automatic bit op_kind_of(input logic [7:0] c, output logic [KIND_W-1:0] kind);
    kind = KIND_ERROR;
    case (c)
      "+": kind = KIND_PLUS;
      "-": kind = KIND_MINUS;
      "*": kind = KIND_STAR;
      "/": kind = KIND_SLASH;
      "=": kind = KIND_ASSIGN;
      ";": kind = KIND_SEMI;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void queue_token(input logic [KIND_W-1:0] kind,
                                      input logic [VALUE_W-1:0] value, input bit ovf,
                                      input logic [POS_BITS-1:0] start,
                                      input logic [LEN_W-1:0] len);
    tok_t t;
    t.kind         = kind;
    t.number_value = value;
    t.overflowed   = ovf;
    t.start_pos    = clamp_pos(start);
    t.token_len    = len;
    t.last_of_run  = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  // a byte that opens a fresh lexeme from the idle state
  function automatic void open_token(input logic [7:0] c);
    logic [KIND_W-1:0] op;
    clear_lexeme();
    tok_start = src_pos;
    if (is_letter(c) || c == "_") begin
      scan_st = SCAN_IDENT;
      grow_ident(c);
    end else if (is_digit_char(c)) begin
      scan_st = SCAN_NUMBER;
      grow_number(c);
    end else if (op_kind_of(c, op)) begin
      queue_token(op, '0, 1'b0, src_pos, LEN_W'(1));
    end else begin
      queue_token(KIND_ERROR, '0, 1'b0, src_pos, '0);
      scan_st = SCAN_ERROR;
    end
  endfunction

  // one accepted source byte: update the model and queue the tokens it completes
  function automatic void lex_byte(input logic [7:0] c, input logic eos);
    bit   term;
    int   prior_cnt;
    tok_t t;
    term      = eos || (c == 8'h00);
    prior_cnt = expected_tokens.size();
    if (!term && scan_st == SCAN_IDENT && is_word_char(c)) begin
      grow_ident(c);
      step_pos();
    end else if (!term && scan_st == SCAN_NUMBER && is_digit_char(c)) begin
      grow_number(c);
      step_pos();
    end else begin
      // close the token this byte cannot extend
      if (scan_st == SCAN_IDENT) begin
        queue_token(ident_kind(), '0, 1'b0, tok_start, run_len);
        scan_st = SCAN_IDLE;
      end else if (scan_st == SCAN_NUMBER) begin
        queue_token(KIND_NUMBER, accum, accum_ovf, tok_start, run_len);
        scan_st = SCAN_IDLE;
      end
      if (term) begin
        queue_token(KIND_EOF, '0, 1'b0, src_pos, '0);
        reset_scanner();
      end else begin
        if (scan_st != SCAN_ERROR && !is_space_char(c)) open_token(c);
        step_pos();
      end
    end
    // flag the final token caused by this byte
    if (expected_tokens.size() > prior_cnt) begin
      t = expected_tokens.pop_back();
      t.last_of_run = 1'b1;
      expected_tokens.push_back(t);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    fail_count++;
    $display("[%0t] mismatch at token %0d: %s expected 0x%0h got 0x%0h",
             $realtime, tokens_checked, what, exp_v, got_v);
  endtask

  task automatic check_token();
    tok_t t;
    if (expected_tokens.size() == 0) begin
      report_mismatch("unexpected token, kind", '0, 32'(out_kind));
    end else begin
      t = expected_tokens.pop_front();
      if (out_kind !== t.kind) report_mismatch("kind", 32'(t.kind), 32'(out_kind));
      if (out_number_value !== t.number_value)
        report_mismatch("number_value", 32'(t.number_value), 32'(out_number_value));
      if (out_overflowed !== t.overflowed)
        report_mismatch("overflowed", 32'(t.overflowed), 32'(out_overflowed));
      if (out_start_pos !== t.start_pos)
        report_mismatch("start_pos", 32'(t.start_pos), 32'(out_start_pos));
      if (out_token_len !== t.token_len)
        report_mismatch("token_len", 32'(t.token_len), 32'(out_token_len));
      if (out_last_of_run !== t.last_of_run)
        report_mismatch("last_of_run", 32'(t.last_of_run), 32'(out_last_of_run));
    end
    tokens_checked++;
  endtask

  // results leave before new bytes are modeled: a byte never yields a token at its own edge
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_scanner();
      expected_tokens.delete();
      pending <= 0;
    end else begin
      if (out_pop && !out_empty) check_token();
      if (in_push && !in_full) lex_byte(in_ch, in_end_of_source);
      pending <= expected_tokens.size();
    end
  end

endmodule

/* verif/tb.sv */
// Testbench top for the keyword lexer stream: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import kls_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int PHASE_ITEMS    = 75;
  localparam int TAIL_CYCLES    = 10;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [7:0]           in_ch;
  logic                 in_end_of_source;
  logic                 out_empty;
  logic                 out_pop;
  logic [KIND_W-1:0]    out_kind;
  logic [VALUE_W-1:0]   out_number_value;
  logic                 out_overflowed;
  logic [LEN_W-1:0]     out_start_pos;
  logic [LEN_W-1:0]     out_token_len;
  logic                 out_last_of_run;

  int fail_count;
  int pending;
  int tokens_checked;
  int cycle_cnt;
  int bytes_sent;
  int sender_idle_pct;
  int recv_stall_pct;

  // bytes of the source text being built
  logic [7:0] src_q[$];

  keyword_lexer_stream_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_ch            (in_ch),
    .in_end_of_source (in_end_of_source),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_kind         (out_kind),
    .out_number_value (out_number_value),
    .out_overflowed   (out_overflowed),
    .out_start_pos    (out_start_pos),
    .out_token_len    (out_token_len),
    .out_last_of_run  (out_last_of_run)
  );

  kls_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_ch            (in_ch),
    .in_end_of_source (in_end_of_source),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_kind         (out_kind),
    .out_number_value (out_number_value),
    .out_overflowed   (out_overflowed),
    .out_start_pos    (out_start_pos),
    .out_token_len    (out_token_len),
    .out_last_of_run  (out_last_of_run),
    .fail_count       (fail_count),
    .pending          (pending),
    .tokens_checked   (tokens_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("keyword_lexer_stream_top verification failed");
      $finish;
    end
  end

  // result side: random stalls at the current phase rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one byte transfer, after a random idle gap
  task automatic send_byte(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push          <= 1'b1;
    in_ch            <= c;
    in_end_of_source <= eos;
    do @(posedge clk); while (in_full);
    bytes_sent++;
  endtask

  // stop sending and wait until every predicted token has come out
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] ws_char();
    case ($urandom_range(5))
      0: return 8'd9;
      1: return 8'd10;
      2: return 8'd11;
      3: return 8'd12;
      4: return 8'd13;
      default: return " ";
    endcase
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] lead_char();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] op_char();
    case ($urandom_range(5))
      0: return "+";
      1: return "-";
      2: return "*";
      3: return "/";
      4: return "=";
      default: return ";";
    endcase
  endfunction

  function automatic logic [7:0] unknown_char();
    if ($urandom_range(1)) return 8'($urandom_range(128, 255));
    case ($urandom_range(9))
      0: return "#";
      1: return "!";
      2: return "(";
      3: return "}";
      4: return "<";
      5: return ".";
      6: return 8'h01;
      7: return 8'h7F;
      8: return 8'h1B;
      default: return 8'h22;
    endcase
  endfunction

  // keyword, sometimes mangled into a plain identifier
  function automatic void push_keyword();
    int k;
    int n;
    int variant;
    logic [7:0] c;
    k = $urandom_range(NUM_KW - 1);
    n = int'(KW_LEN[k]);
    variant = $urandom_range(9);
    if (variant == 9 && n > 2) n--;
    for (int i = 0; i < n; i++) begin
      c = KW_TEXT[k][8*i +: 8];
      if (variant == 8 && i == 0) c = c ^ 8'h20;
      src_q.push_back(c);
    end
    if (variant == 7) src_q.push_back(word_char());
  endfunction

  function automatic void push_ident();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    src_q.push_back(lead_char());
    for (int i = 1; i < n; i++) src_q.push_back(word_char());
  endfunction

  function automatic void push_number();
    int n;
    n = ($urandom_range(7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) src_q.push_back(8'("0" + $urandom_range(9)));
  endfunction

  // a mostly well-formed text; returns the number of bytes before any trailing noise
  function automatic int build_text();
    int n_tok;
    int r;
    int counted;
    src_q.delete();
    n_tok = $urandom_range(1, 8);
    for (int t = 0; t < n_tok; t++) begin
      r = $urandom_range(99);
      if (r < 25) push_keyword();
      else if (r < 45) push_ident();
      else if (r < 65) push_number();
      else if (r < 85) src_q.push_back(op_char());
      else src_q.push_back(ws_char());
      r = $urandom_range(99);
      if (r < 45) src_q.push_back(ws_char());
      else if (r < 55) repeat ($urandom_range(2, 3)) src_q.push_back(ws_char());
    end
    counted = src_q.size();
    // occasionally break the text with an unknown byte and trailing noise
    if ($urandom_range(9) == 0) begin
      src_q.push_back(unknown_char());
      counted++;
      repeat ($urandom_range(0, 4)) src_q.push_back(8'($urandom_range(1, 255)));
    end
    return counted;
  endfunction

  // send the built text, then a terminator of either form
  task automatic send_text();
    foreach (src_q[i]) send_byte(src_q[i], 1'b0);
    if ($urandom_range(1)) send_byte(8'($urandom_range(255)), 1'b1);
    else send_byte(8'h00, 1'b0);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    int done;
    sender_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    done = 0;
    while (done < PHASE_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        // raw noise, always closed by a zero byte with the end flag set
        src_q.delete();
        repeat ($urandom_range(1, 10)) src_q.push_back(8'($urandom_range(255)));
        foreach (src_q[i]) send_byte(src_q[i], 1'(($urandom_range(15) == 0)));
        send_byte(8'h00, 1'b1);
      end else begin
        done += build_text();
        send_text();
      end
    end
    drain();
  endtask

  initial begin
    logic [7:0] directed[$];
    cycle_cnt        = 0;
    bytes_sent       = 0;
    sender_idle_pct  = 0;
    recv_stall_pct   = 0;
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_ch            = 8'h00;
    in_end_of_source = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keyword, all operators, identifier, overflowing number,
    // high byte as error, ignored tail, terminator by flag and by zero byte
    directed = '{"i", "f", "+", "-", "*", "/", "=", ";", "_", "Z", "9", " ",
                 "9", "9", "9", "9", "9", "9", "9", "9", "9", "9", 8'd9,
                 8'hFF, 8'h80};
    foreach (directed[i]) send_byte(directed[i], 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte("7", 1'b0);
    send_byte(8'h00, 1'b0);
    drain();

    // random texts under each pacing mix
    run_random_phase(0, 0);
    run_random_phase(70, 0);
    run_random_phase(0, 70);
    run_random_phase(34, 34);

    // let any stray result show up
    recv_stall_pct <= 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d source bytes: directed tokens, overflow and error cases,",
             bytes_sent);
    $display("and random texts under four pacing mixes; %0d tokens compared",
             tokens_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("keyword_lexer_stream_top verification clean");
    end else begin
      $display("keyword_lexer_stream_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/kls_pkg.sv
sv/kls_front.sv
sv/kls_queue.sv
sv/kls_back.sv
sv/keyword_lexer_stream_top.sv
verif/kls_checker.sv
verif/tb.sv
